// ===== hw/rtl/fbfl_pkg.sv =====
// Shared types and constants for the fixed-block free-list allocator.
`timescale 1ns / 1ps
`default_nettype none

package fbfl_pkg;

  localparam int HANDLE_W        = 10;
  localparam int STORE_DEPTH     = 1024;
  localparam int LINK_W          = HANDLE_W + 1;
  localparam int BPC_W           = 7;
  localparam int SIZE_EXT_W      = 9;
  localparam int OUT_CNT_W       = 5;
  localparam int STATUS_W        = 2;
  localparam int MAX_CHUNKS_DEF  = 16;
  localparam int MAX_BPC_DEF     = 64;

  localparam logic [BPC_W-1:0] BPC_RESET = 7'd64;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NO_CHUNKS = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NULL_FREE = 2'd2;
  localparam logic [STATUS_W-1:0] ST_BAD_FREE  = 2'd3;

  typedef struct packed {
    logic                opcode;
    logic                handle_present;
    logic [HANDLE_W-1:0] free_handle;
  } in_item_t;

  typedef struct packed {
    logic [HANDLE_W-1:0]  alloc_handle;
    logic [STATUS_W-1:0]  status;
    logic [OUT_CNT_W-1:0] chunks_open;
  } out_item_t;

  typedef enum logic [2:0] {
    ACT_NONE  = 3'd0,
    ACT_POP   = 3'd1,
    ACT_FRESH = 3'd2,
    ACT_OPEN  = 3'd3,
    ACT_PUSH  = 3'd4,
    ACT_FAIL  = 3'd5
  } act_t;

  typedef struct packed {
    logic                load;
    act_t                act;
    logic [STATUS_W-1:0] status;
    logic                emit;
  } dp_cmd_t;

  typedef struct packed {
    logic opcode;
    logic handle_present;
    logic freed_nonempty;
    logic fresh_avail;
    logic chunks_full;
    logic in_range;
  } dp_stat_t;

endpackage

`default_nettype wire

// ===== hw/rtl/fixed_block_free_list_allocator.sv =====
// Top level of the fixed-block free-list allocator.
//
// Usage:
//   Input: an item (allocate or free) transfers when start is high and busy
//   is low. busy stays high for the one execute cycle that follows.
//   Output: one result per item, shown for a single cycle with out_valid.
//   The receiver cannot stall; a result must be taken in that cycle.
//   Config: blocks_per_chunk transfers on cfg_valid && cfg_ready; cfg_ready
//   is high whenever no item is executing. The new size applies to chunks
//   opened afterwards.
//   Timing: an item is accepted, then executed in the next cycle; out_valid
//   is registered at the end of the execute cycle. No new item is accepted
//   while one executes; a popped freed handle comes from the registered
//   read of the link memory that is made at the accept.
//   Reset (rst_n low, synchronous): the pool is empty, no chunks are open
//   and blocks_per_chunk returns to 64. The link memory is not cleared.
`timescale 1ns / 1ps
`default_nettype none

module fixed_block_free_list_allocator #(
  parameter int MAX_CHUNKS           = fbfl_pkg::MAX_CHUNKS_DEF,
  parameter int MAX_BLOCKS_PER_CHUNK = fbfl_pkg::MAX_BPC_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       start,
  output logic                            busy,
  input  wire fbfl_pkg::in_item_t         in_item,
  input  wire logic                       cfg_valid,
  output logic                            cfg_ready,
  input  wire logic [fbfl_pkg::BPC_W-1:0] cfg_data,
  output logic                            out_valid,
  output fbfl_pkg::out_item_t             out_result
);

  fbfl_pkg::dp_cmd_t  cmd;
  fbfl_pkg::dp_stat_t stat;
  logic               cfg_we;

  assign cfg_ready = !busy;
  assign cfg_we    = cfg_valid && cfg_ready;

  fbfl_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .stat  (stat),
    .busy  (busy),
    .cmd   (cmd)
  );

  fbfl_dp #(
    .MAX_CHUNKS           (MAX_CHUNKS),
    .MAX_BLOCKS_PER_CHUNK (MAX_BLOCKS_PER_CHUNK)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_item    (in_item),
    .cfg_we     (cfg_we),
    .cfg_data   (cfg_data),
    .cmd        (cmd),
    .stat       (stat),
    .out_valid  (out_valid),
    .out_result (out_result)
  );

endmodule

`default_nettype wire

// ===== hw/rtl/fbfl_ram.sv =====
// Generic single-port-write, registered-read RAM.
`timescale 1ns / 1ps
`default_nettype none

module fbfl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/fbfl_ctrl.sv =====
// Controller: accepts items and decodes the allocate/free action.
`timescale 1ns / 1ps
`default_nettype none

module fbfl_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  input  wire fbfl_pkg::dp_stat_t stat,
  output logic                   busy,
  output fbfl_pkg::dp_cmd_t      cmd
);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EXEC = 2'b10
  } state_t;

  state_t state_r;
  state_t state_nxt;
  logic   accept;

  assign busy   = (state_r == S_EXEC);
  assign accept = start && (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // action decode during the execute cycle
  always_comb begin
    cmd        = '0;
    cmd.act    = fbfl_pkg::ACT_NONE;
    cmd.status = fbfl_pkg::ST_OK;
    cmd.load   = accept;
    cmd.emit   = (state_r == S_EXEC);
    if (state_r == S_EXEC) begin
      if (stat.opcode == fbfl_pkg::OP_ALLOC) begin
        if (stat.freed_nonempty) begin
          cmd.act = fbfl_pkg::ACT_POP;
        end else if (stat.fresh_avail) begin
          cmd.act = fbfl_pkg::ACT_FRESH;
        end else if (stat.chunks_full) begin
          cmd.act    = fbfl_pkg::ACT_FAIL;
          cmd.status = fbfl_pkg::ST_NO_CHUNKS;
        end else begin
          cmd.act = fbfl_pkg::ACT_OPEN;
        end
      end else begin
        if (!stat.handle_present) begin
          cmd.act    = fbfl_pkg::ACT_FAIL;
          cmd.status = fbfl_pkg::ST_NULL_FREE;
        end else if (!stat.in_range) begin
          cmd.act    = fbfl_pkg::ACT_FAIL;
          cmd.status = fbfl_pkg::ST_BAD_FREE;
        end else begin
          cmd.act = fbfl_pkg::ACT_PUSH;
        end
      end
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/fbfl_dp.sv =====
// Datapath: freed stack, chunk counters, link memory and result register.
`timescale 1ns / 1ps
`default_nettype none

module fbfl_dp #(
  parameter int MAX_CHUNKS           = fbfl_pkg::MAX_CHUNKS_DEF,
  parameter int MAX_BLOCKS_PER_CHUNK = fbfl_pkg::MAX_BPC_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire fbfl_pkg::in_item_t            in_item,
  input  wire logic                          cfg_we,
  input  wire logic [fbfl_pkg::BPC_W-1:0]    cfg_data,
  input  wire fbfl_pkg::dp_cmd_t             cmd,
  output fbfl_pkg::dp_stat_t                 stat,
  output logic                               out_valid,
  output fbfl_pkg::out_item_t                out_result
);

  localparam int HW    = fbfl_pkg::HANDLE_W;
  localparam int CW    = $clog2(MAX_CHUNKS + 1);
  localparam int SW    = $clog2(MAX_BLOCKS_PER_CHUNK + 1);
  localparam int SUM_W = HW + 1;
  localparam int XW    = fbfl_pkg::SIZE_EXT_W;
  localparam int LW    = fbfl_pkg::LINK_W;

  fbfl_pkg::in_item_t        item_r;
  logic [fbfl_pkg::BPC_W-1:0] bpc_r;
  logic [HW-1:0]             freed_head_r,     freed_head_nxt;
  logic                      freed_nonempty_r, freed_nonempty_nxt;
  logic [CW-1:0]             chunk_count_r,    chunk_count_nxt;
  logic [SW-1:0]             fresh_index_r,    fresh_index_nxt;
  logic [HW-1:0]             chunk_base_r,     chunk_base_nxt;
  logic [SW-1:0]             chunk_size_r,     chunk_size_nxt;
  logic                      out_valid_r;
  fbfl_pkg::out_item_t       out_item_r,       out_item_nxt;

  logic [XW-1:0]    bpc_ext;
  logic [XW-1:0]    eff_ext;
  logic [SUM_W-1:0] limit;
  logic [HW-1:0]    handle_nxt;
  logic             wr_en;
  logic [LW-1:0]    rd_data;

  // clamp the configured size into 1 .. MAX_BLOCKS_PER_CHUNK
  assign bpc_ext = XW'(bpc_r);
  always_comb begin
    eff_ext = bpc_ext;
    if (bpc_ext == '0) begin
      eff_ext = XW'(1);
    end else if (bpc_ext > XW'(MAX_BLOCKS_PER_CHUNK)) begin
      eff_ext = XW'(MAX_BLOCKS_PER_CHUNK);
    end
  end

  assign limit = SUM_W'(chunk_base_r) + SUM_W'(chunk_size_r);

  assign stat.opcode         = item_r.opcode;
  assign stat.handle_present = item_r.handle_present;
  assign stat.freed_nonempty = freed_nonempty_r;
  assign stat.fresh_avail    = (chunk_count_r != '0) && (fresh_index_r < chunk_size_r);
  assign stat.chunks_full    = (chunk_count_r >= CW'(MAX_CHUNKS));
  assign stat.in_range       = (chunk_count_r != '0) &&
                               (SUM_W'(item_r.free_handle) < limit);

  assign wr_en = (cmd.act == fbfl_pkg::ACT_PUSH);

  fbfl_ram #(
    .WIDTH (LW),
    .DEPTH (fbfl_pkg::STORE_DEPTH)
  ) u_link_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (item_r.free_handle),
    .wr_data ({freed_nonempty_r, freed_head_r}),
    .rd_en   (cmd.load),
    .rd_addr (freed_head_r),
    .rd_data (rd_data)
  );

  always_comb begin
    freed_head_nxt     = freed_head_r;
    freed_nonempty_nxt = freed_nonempty_r;
    chunk_count_nxt    = chunk_count_r;
    fresh_index_nxt    = fresh_index_r;
    chunk_base_nxt     = chunk_base_r;
    chunk_size_nxt     = chunk_size_r;
    handle_nxt         = '0;
    unique case (cmd.act)
      fbfl_pkg::ACT_POP: begin
        handle_nxt         = freed_head_r;
        freed_nonempty_nxt = rd_data[LW-1];
        freed_head_nxt     = rd_data[HW-1:0];
      end
      fbfl_pkg::ACT_FRESH: begin
        handle_nxt      = HW'(chunk_base_r + HW'(fresh_index_r));
        fresh_index_nxt = fresh_index_r + SW'(1);
      end
      fbfl_pkg::ACT_OPEN: begin
        if (chunk_count_r != '0) begin
          chunk_base_nxt = HW'(chunk_base_r + HW'(chunk_size_r));
        end else begin
          chunk_base_nxt = '0;
        end
        chunk_size_nxt  = SW'(eff_ext);
        chunk_count_nxt = chunk_count_r + CW'(1);
        fresh_index_nxt = SW'(1);
        handle_nxt      = chunk_base_nxt;
      end
      fbfl_pkg::ACT_PUSH: begin
        freed_head_nxt     = item_r.free_handle;
        freed_nonempty_nxt = 1'b1;
      end
      fbfl_pkg::ACT_FAIL, fbfl_pkg::ACT_NONE: begin
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    out_item_nxt.alloc_handle = handle_nxt;
    out_item_nxt.status       = cmd.status;
    out_item_nxt.chunks_open  = fbfl_pkg::OUT_CNT_W'(chunk_count_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bpc_r            <= fbfl_pkg::BPC_RESET;
      freed_head_r     <= '0;
      freed_nonempty_r <= 1'b0;
      chunk_count_r    <= '0;
      fresh_index_r    <= '0;
      chunk_base_r     <= '0;
      chunk_size_r     <= '0;
      out_valid_r      <= 1'b0;
    end else begin
      if (cfg_we) begin
        bpc_r <= cfg_data;
      end
      freed_head_r     <= freed_head_nxt;
      freed_nonempty_r <= freed_nonempty_nxt;
      chunk_count_r    <= chunk_count_nxt;
      fresh_index_r    <= fresh_index_nxt;
      chunk_base_r     <= chunk_base_nxt;
      chunk_size_r     <= chunk_size_nxt;
      out_valid_r      <= cmd.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item_r <= in_item;
    end
    if (cmd.emit) begin
      out_item_r <= out_item_nxt;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_result = out_item_r;

endmodule

`default_nettype wire

// ===== hw/rtl/fbfl_checker.sv =====
// Port-level checker for the allocator, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module fbfl_checker (
  input wire logic                clk,
  input wire logic                rst_n,
  input wire logic                start,
  input wire logic                busy,
  input wire logic                out_valid,
  input wire fbfl_pkg::out_item_t out_result
);

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("busy not raised after transfer");

  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |-> ##2 out_valid)
    else $error("missing result two cycles after transfer");

  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe longer than one cycle");

  a_fail_zero_handle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_result.status != fbfl_pkg::ST_OK) |->
      (out_result.alloc_handle == '0))
    else $error("nonzero handle on failed item");

endmodule

bind fixed_block_free_list_allocator fbfl_checker u_fbfl_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .start      (start),
  .busy       (busy),
  .out_valid  (out_valid),
  .out_result (out_result)
);

`default_nettype wire

// ===== sim/tb_fixed_block_free_list_allocator.sv =====
// Self-checking testbench for the fixed-block free-list allocator.
`timescale 1ns / 1ps
`default_nettype none

module tb_fixed_block_free_list_allocator;
  import fbfl_pkg::*;

  localparam int STALL_LIMIT  = 1000;
  localparam int DRAIN_CYCLES = 8;
  localparam int PHASE_ITEMS  = 500;
  localparam int PLAN_LEN     = 17;

  typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

  typedef struct packed {
    row_kind_t        kind;
    in_item_t         item;
    logic [BPC_W-1:0] cfg_value;
    logic             typed;
    out_item_t        want;
  } plan_row_t;

  localparam plan_row_t DIRECTED [PLAN_LEN] = '{
    '{ROW_ITEM, '{OP_FREE,  1'b1, 10'd0},    7'd0, 1'b1, '{10'd0, ST_BAD_FREE,  5'd0}},
    '{ROW_ITEM, '{OP_FREE,  1'b0, 10'd1023}, 7'd0, 1'b1, '{10'd0, ST_NULL_FREE, 5'd0}},
    '{ROW_ITEM, '{OP_ALLOC, 1'b0, 10'd0},    7'd0, 1'b1, '{10'd0, ST_OK,        5'd1}},
    '{ROW_ITEM, '{OP_ALLOC, 1'b0, 10'd0},    7'd0, 1'b0, '{10'd0, ST_OK,        5'd0}},
    '{ROW_ITEM, '{OP_FREE,  1'b1, 10'd64},   7'd0, 1'b1, '{10'd0, ST_BAD_FREE,  5'd1}},
    '{ROW_ITEM, '{OP_FREE,  1'b1, 10'd1023}, 7'd0, 1'b1, '{10'd0, ST_BAD_FREE,  5'd1}},
    '{ROW_ITEM, '{OP_FREE,  1'b1, 10'd63},   7'd0, 1'b1, '{10'd0, ST_OK,        5'd1}},
    '{ROW_ITEM, '{OP_FREE,  1'b1, 10'd63},   7'd0, 1'b1, '{10'd0, ST_OK,        5'd1}},
    '{ROW_ITEM, '{OP_ALLOC, 1'b0, 10'd0},    7'd0, 1'b0, '{10'd0, ST_OK,        5'd0}},
    '{ROW_ITEM, '{OP_ALLOC, 1'b1, 10'd1023}, 7'd0, 1'b0, '{10'd0, ST_OK,        5'd0}},
    '{ROW_CFG,  '{OP_ALLOC, 1'b0, 10'd0},    7'd0, 1'b0, '{10'd0, ST_OK,        5'd0}},
    '{ROW_ITEM, '{OP_FREE,  1'b1, 10'd63},   7'd0, 1'b1, '{10'd0, ST_OK,        5'd1}},
    '{ROW_ITEM, '{OP_FREE,  1'b0, 10'd0},    7'd0, 1'b1, '{10'd0, ST_NULL_FREE, 5'd1}},
    '{ROW_ITEM, '{OP_ALLOC, 1'b0, 10'd0},    7'd0, 1'b0, '{10'd0, ST_OK,        5'd0}},
    '{ROW_ITEM, '{OP_FREE,  1'b1, 10'd1},    7'd0, 1'b1, '{10'd0, ST_OK,        5'd1}},
    '{ROW_ITEM, '{OP_ALLOC, 1'b0, 10'd0},    7'd0, 1'b0, '{10'd0, ST_OK,        5'd0}},
    '{ROW_ITEM, '{OP_ALLOC, 1'b0, 10'd0},    7'd0, 1'b0, '{10'd0, ST_OK,        5'd0}}
  };

  logic             clk       = 1'b0;
  logic             rst_n     = 1'b0;
  logic             start     = 1'b0;
  in_item_t         in_item   = '0;
  logic             cfg_valid = 1'b0;
  logic [BPC_W-1:0] cfg_data  = '0;
  logic             busy;
  logic             cfg_ready;
  logic             out_valid;
  out_item_t        out_result;

  // pool mirror
  logic [HANDLE_W-1:0]  next_link [STORE_DEPTH];
  logic                 next_more [STORE_DEPTH];
  logic [HANDLE_W-1:0]  freed_top   = '0;
  logic                 freed_any   = 1'b0;
  logic [OUT_CNT_W-1:0] chunks_used = '0;
  logic [BPC_W-1:0]     next_fresh  = '0;
  logic [HANDLE_W-1:0]  base_handle = '0;
  logic [BPC_W-1:0]     open_size   = '0;
  logic [BPC_W-1:0]     size_reg    = BPC_RESET;

  out_item_t           pending_results [$];
  logic [HANDLE_W-1:0] held_q [$];
  logic [HANDLE_W-1:0] last_freed = '0;
  out_item_t           oldest_result;
  int                  mismatch_count = 0;
  int                  idle_cycles = 0;
  int                  sender_idle_pct = 18;

  fixed_block_free_list_allocator u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_item    (in_item),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .out_valid  (out_valid),
    .out_result (out_result)
  );

  always #6 clk = ~clk;

  function automatic out_item_t predict_pool_result(input in_item_t it);
    out_item_t r;
    r = '0;
    if (it.opcode == OP_ALLOC) begin
      if (freed_any) begin
        r.alloc_handle = freed_top;
        freed_any = next_more[freed_top];
        freed_top = next_link[freed_top];
      end else if (chunks_used != 0 && next_fresh < open_size) begin
        r.alloc_handle = base_handle + HANDLE_W'(next_fresh);
        next_fresh = next_fresh + 1'b1;
      end else if (int'(chunks_used) >= MAX_CHUNKS_DEF) begin
        r.status = ST_NO_CHUNKS;
      end else begin
        base_handle = (chunks_used != 0) ? base_handle + HANDLE_W'(open_size) : '0;
        if (size_reg == 0)
          open_size = BPC_W'(1);
        else if (int'(size_reg) > MAX_BPC_DEF)
          open_size = BPC_W'(MAX_BPC_DEF);
        else
          open_size = size_reg;
        chunks_used = chunks_used + 1'b1;
        next_fresh = BPC_W'(1);
        r.alloc_handle = base_handle;
      end
    end else if (!it.handle_present) begin
      r.status = ST_NULL_FREE;
    end else if (chunks_used == 0 ||
                 int'(it.free_handle) >= int'(base_handle) + int'(open_size)) begin
      r.status = ST_BAD_FREE;
    end else begin
      next_link[it.free_handle] = freed_top;
      next_more[it.free_handle] = freed_any;
      freed_top = it.free_handle;
      freed_any = 1'b1;
    end
    r.chunks_open = chunks_used;
    return r;
  endfunction

  task automatic send_item(input in_item_t it, input logic typed, input out_item_t want);
    out_item_t r;
    start   <= 1'b1;
    in_item <= it;
    do @(posedge clk); while (busy !== 1'b0);
    r = predict_pool_result(it);
    if (it.opcode == OP_ALLOC && r.status == ST_OK)
      held_q.push_back(r.alloc_handle);
    pending_results.push_back(typed ? want : r);
    if ($urandom_range(99) < sender_idle_pct) begin
      start <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < sender_idle_pct);
    end
  endtask

  // only while idle: drain every pending result first
  task automatic write_size(input logic [BPC_W-1:0] v);
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    cfg_valid <= 1'b0;
    size_reg = v;
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1) begin
      if (pending_results.size() == 0) begin
        if (mismatch_count < 10)
          $display("result with none pending: handle %0d status %0d chunks %0d",
                   out_result.alloc_handle, out_result.status, out_result.chunks_open);
        mismatch_count++;
      end else begin
        oldest_result = pending_results.pop_front();
        if (out_result.alloc_handle !== oldest_result.alloc_handle ||
            out_result.status !== oldest_result.status ||
            out_result.chunks_open !== oldest_result.chunks_open) begin
          if (mismatch_count < 10)
            $display("mismatch: exp handle %0d status %0d chunks %0d, got %0d %0d %0d",
                     oldest_result.alloc_handle, oldest_result.status,
                     oldest_result.chunks_open, out_result.alloc_handle,
                     out_result.status, out_result.chunks_open);
          mismatch_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    in_item_t         it;
    int               alloc_pct;
    int               sel;
    int               idx;
    logic [BPC_W-1:0] phase_size;

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < PLAN_LEN; i++) begin
      if (DIRECTED[i].kind == ROW_CFG)
        write_size(DIRECTED[i].cfg_value);
      else
        send_item(DIRECTED[i].item, DIRECTED[i].typed, DIRECTED[i].want);
    end

    // mid size, then above range, then zero with heavy allocation to run out of chunks
    for (int p = 0; p < 3; p++) begin
      case (p)
        0: begin
          sender_idle_pct = 18;
          alloc_pct = 60;
          phase_size = BPC_W'($urandom_range(63, 2));
        end
        1: begin
          sender_idle_pct = 68;
          alloc_pct = 60;
          phase_size = 7'd127;
        end
        default: begin
          sender_idle_pct = 0;
          alloc_pct = 75;
          phase_size = 7'd0;
        end
      endcase
      write_size(phase_size);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        it = '0;
        it.free_handle = HANDLE_W'($urandom_range(1023));
        it.handle_present = 1'($urandom_range(1));
        sel = $urandom_range(99);
        if ($urandom_range(99) < alloc_pct) begin
          it.opcode = OP_ALLOC;
        end else begin
          it.opcode = OP_FREE;
          it.handle_present = 1'b1;
          if (sel < 75 && held_q.size() > 0) begin
            idx = $urandom_range(held_q.size() - 1);
            it.free_handle = held_q[idx];
            last_freed = held_q[idx];
            held_q.delete(idx);
          end else if (sel < 85) begin
            it.free_handle = last_freed;
          end else if (sel >= 93) begin
            it.handle_present = 1'b0;
          end
        end
        send_item(it, 1'b0, '0);
      end
    end

    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule

`default_nettype wire
